>>> hdl/bgc_pkg.sv
// bgc_pkg: shared types and codes for the bipartite graph check block
// no dependencies
`default_nettype none
package bgc_pkg;
  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_CHECK = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [1:0] COL_NONE = 2'd0;
  localparam logic [1:0] COL_ONE  = 2'd1;
  localparam logic [1:0] COL_TWO  = 2'd2;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ADD_RD,
    OP_ADD_WR,
    OP_CLR_GRAPH,
    OP_CLR_COL,
    OP_SCAN_RD,
    OP_SCAN_CHK,
    OP_TOP_RD,
    OP_TOP_LAT,
    OP_TOP_DEG,
    OP_ADJ_RD,
    OP_NBR_RD,
    OP_NBR_CHK,
    OP_DONE
  } op_t;

  typedef struct packed {
    logic scan_done;
    logic scan_uncol;
    logic stack_empty;
    logic slot_end;
    logic nbr_skip;
    logic nbr_same;
    logic nbr_uncol;
    logic stack_full;
    logic sweep_end;
  } status_t;
endpackage
`default_nettype wire

>>> hdl/bgc_ram.sv
// bgc_ram: generic single-port-write, one-read RAM with registered read
// no dependencies
`default_nettype none
module bgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hdl/bgc_datapath.sv
// bgc_datapath: graph memories, colour store, walk stack and counters
// depends on bgc_pkg and bgc_ram
`default_nettype none
module bgc_datapath #(
  parameter int MAX_NODES  = 1024,
  parameter int MAX_DEGREE = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bgc_pkg::op_t      op,
  input  wire logic              start_cmd,
  input  wire logic [10:0]       node_count,
  input  wire logic [10:0]       edge_from,
  input  wire logic [10:0]       edge_to,
  output bgc_pkg::status_t       st,
  output logic                   add_valid,
  output logic                   overflow
);
  import bgc_pkg::*;
  localparam int NW = $clog2(MAX_NODES);
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int SW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int AW = $clog2(MAX_NODES * MAX_DEGREE);
  localparam int PW = $clog2(MAX_NODES + 1);
  localparam int CW = (NW > 11) ? NW + 1 : 12;

  logic [CW-1:0] limit;
  always_comb begin
    limit = CW'(node_count);
    if (limit > CW'(MAX_NODES)) limit = CW'(MAX_NODES);
  end

  // latched command
  logic [NW-1:0] from_idx_r;
  logic [10:0]   to_r;
  logic          from_ok_r;
  always_ff @(posedge clk) begin
    if (start_cmd) begin
      from_idx_r <= NW'(edge_from - 11'd1);
      to_r       <= edge_to;
      from_ok_r  <= (edge_from != 11'd0) && ({1'b0, edge_from} <= 12'(MAX_NODES));
    end
  end
  assign add_valid = from_ok_r;

  // degree ram
  logic          deg_we;
  logic [NW-1:0] deg_waddr, deg_raddr;
  logic [DW-1:0] deg_wdata, deg_rdata;
  bgc_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_deg (
    .clk, .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .raddr(deg_raddr), .rdata(deg_rdata));

  // colour ram
  logic          col_we;
  logic [NW-1:0] col_waddr, col_raddr;
  logic [1:0]    col_wdata, col_rdata;
  bgc_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_col (
    .clk, .we(col_we), .waddr(col_waddr), .wdata(col_wdata),
    .raddr(col_raddr), .rdata(col_rdata));

  // adjacency ram
  logic          adj_we;
  logic [AW-1:0] adj_waddr, adj_raddr;
  logic [10:0]   adj_rdata;
  bgc_ram #(.WIDTH(11), .DEPTH(MAX_NODES * MAX_DEGREE)) u_adj (
    .clk, .we(adj_we), .waddr(adj_waddr), .wdata(to_r),
    .raddr(adj_raddr), .rdata(adj_rdata));

  // stack ram: node index and slot
  logic          stk_we;
  logic [NW-1:0] stk_waddr, stk_raddr;
  logic [NW+DW-1:0] stk_wdata, stk_rdata;
  bgc_ram #(.WIDTH(NW + DW), .DEPTH(MAX_NODES)) u_stk (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));

  logic [NW-1:0] sweep_r;
  logic [CW-1:0] scan_r;
  logic [PW-1:0] sp_r;
  logic [NW-1:0] v_r, u_r;
  logic [DW-1:0] slot_r;
  logic [1:0]    cv_r;
  logic          ovf_r;
  logic [NW-1:0] top;
  assign top = NW'(sp_r - PW'(1));
  assign overflow = ovf_r;

  // clear passes run over all entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (op == OP_CLR_GRAPH || op == OP_CLR_COL) sweep_r <= sweep_r + NW'(1);
      else sweep_r <= '0;
      if (op == OP_CLR_GRAPH && sweep_r == NW'(MAX_NODES - 1)) ovf_r <= 1'b0;
      if (op == OP_ADD_WR && deg_rdata >= DW'(MAX_DEGREE)) ovf_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      case (op)
        OP_CLR_COL:  sp_r <= '0;
        OP_SCAN_CHK: if (col_rdata == COL_NONE && scan_r <= limit) sp_r <= sp_r + PW'(1);
        OP_TOP_DEG:  if (slot_r >= deg_rdata) sp_r <= sp_r - PW'(1);
        OP_NBR_CHK:  if (col_rdata == COL_NONE && sp_r < PW'(MAX_NODES))
                       sp_r <= sp_r + PW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_CLR_COL) scan_r <= CW'(1);
    else if (op == OP_SCAN_CHK && col_rdata != COL_NONE) scan_r <= scan_r + CW'(1);
    else if (op == OP_SCAN_CHK && sp_r == '0 && scan_r > limit) scan_r <= scan_r;
    if (op == OP_TOP_LAT) begin
      v_r    <= stk_rdata[NW+DW-1:DW];
      slot_r <= stk_rdata[DW-1:0];
    end
    if (op == OP_ADJ_RD) cv_r <= col_rdata;
    if (op == OP_NBR_RD) u_r <= NW'(adj_rdata - 11'd1);
  end

  logic nbr_skip;
  assign nbr_skip = (adj_rdata == 11'd0) || (CW'(adj_rdata) > limit);

  always_comb begin
    deg_we = 1'b0; deg_waddr = from_idx_r; deg_wdata = deg_rdata + DW'(1);
    deg_raddr = from_idx_r;
    col_we = 1'b0; col_waddr = sweep_r; col_wdata = COL_NONE;
    col_raddr = NW'(scan_r - CW'(1));
    adj_we = 1'b0;
    adj_waddr = AW'(from_idx_r * MAX_DEGREE + SW'(deg_rdata));
    adj_raddr = AW'(v_r * MAX_DEGREE + SW'(slot_r));
    stk_we = 1'b0; stk_waddr = NW'(sp_r); stk_wdata = '0; stk_raddr = top;
    unique case (op)
      OP_ADD_WR: begin
        if (deg_rdata < DW'(MAX_DEGREE)) begin
          deg_we = 1'b1; adj_we = 1'b1;
        end
      end
      OP_CLR_GRAPH: begin
        deg_we = 1'b1; deg_waddr = sweep_r; deg_wdata = '0;
      end
      OP_CLR_COL: col_we = 1'b1;
      OP_SCAN_CHK: begin
        if (col_rdata == COL_NONE && scan_r <= limit) begin
          col_we = 1'b1; col_waddr = NW'(scan_r - CW'(1)); col_wdata = COL_ONE;
          stk_we = 1'b1; stk_wdata = {NW'(scan_r - CW'(1)), DW'(0)};
        end
      end
      OP_TOP_LAT: deg_raddr = stk_rdata[NW+DW-1:DW];
      OP_TOP_DEG: begin
        col_raddr = v_r;
        if (slot_r < deg_rdata) begin
          stk_we = 1'b1; stk_waddr = top; stk_wdata = {v_r, slot_r + DW'(1)};
        end
      end
      OP_ADJ_RD: col_raddr = v_r;
      OP_NBR_RD: col_raddr = NW'(adj_rdata - 11'd1);
      OP_NBR_CHK: begin
        col_raddr = u_r;
        if (col_rdata == COL_NONE && sp_r < PW'(MAX_NODES)) begin
          col_we = 1'b1; col_waddr = u_r;
          col_wdata = (cv_r == COL_ONE) ? COL_TWO : COL_ONE;
          stk_we = 1'b1; stk_wdata = {u_r, DW'(0)};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    st.scan_done   = scan_r > limit;
    st.scan_uncol  = col_rdata == COL_NONE;
    st.stack_empty = sp_r == '0;
    st.slot_end    = slot_r >= deg_rdata;
    st.nbr_skip    = nbr_skip;
    st.nbr_same    = col_rdata == cv_r;
    st.nbr_uncol   = col_rdata == COL_NONE;
    st.stack_full  = sp_r >= PW'(MAX_NODES);
    st.sweep_end   = sweep_r == NW'(MAX_NODES - 1);
  end
endmodule
`default_nettype wire

>>> hdl/bgc_ctrl.sv
// bgc_ctrl: command sequencer for add, clear and the depth-first check
// depends on bgc_pkg
`default_nettype none
module bgc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [1:0]       in_action,
  input  wire logic             add_valid,
  input  wire logic             overflow,
  input  wire bgc_pkg::status_t st,
  output bgc_pkg::op_t          op,
  output logic                  busy,
  output logic                  start_cmd,
  output logic                  out_valid,
  output logic                  out_is_bipartite,
  output logic                  out_edges_dropped
);
  import bgc_pkg::*;
  op_t op_r, op_nxt;
  logic done_r, res_nxt, res_r;
  assign op = op_r;
  assign busy = op_r != OP_IDLE;
  assign start_cmd = start && !busy;

  always_comb begin
    op_nxt = op_r;
    res_nxt = res_r;
    unique case (op_r)
      OP_IDLE: if (start) begin
        unique case (action_t'(in_action))
          ACT_ADD:   op_nxt = OP_ADD_RD;
          ACT_CHECK: op_nxt = OP_CLR_COL;
          ACT_CLEAR: op_nxt = OP_CLR_GRAPH;
          default:   op_nxt = OP_IDLE;
        endcase
      end
      OP_ADD_RD:    op_nxt = add_valid ? OP_ADD_WR : OP_IDLE;
      OP_ADD_WR:    op_nxt = OP_IDLE;
      OP_CLR_GRAPH: if (st.sweep_end) op_nxt = OP_IDLE;
      OP_CLR_COL:   if (st.sweep_end) op_nxt = OP_SCAN_RD;
      OP_SCAN_RD: begin
        if (st.scan_done) begin
          res_nxt = 1'b1; op_nxt = OP_DONE;
        end else op_nxt = OP_SCAN_CHK;
      end
      OP_SCAN_CHK: op_nxt = st.scan_uncol ? OP_TOP_RD : OP_SCAN_RD;
      OP_TOP_RD:   op_nxt = OP_TOP_LAT;
      OP_TOP_LAT:  op_nxt = OP_TOP_DEG;
      OP_TOP_DEG:  op_nxt = st.slot_end ? OP_TOP_RD : OP_ADJ_RD;
      OP_ADJ_RD:   op_nxt = OP_NBR_RD;
      OP_NBR_RD:   op_nxt = st.nbr_skip ? OP_TOP_RD : OP_NBR_CHK;
      OP_NBR_CHK: begin
        if (st.nbr_same) begin
          res_nxt = 1'b0; op_nxt = OP_DONE;
        end else if (st.nbr_uncol && st.stack_full) begin
          res_nxt = 1'b1; op_nxt = OP_DONE;
        end else op_nxt = OP_TOP_RD;
      end
      OP_DONE: op_nxt = OP_IDLE;
      default: op_nxt = OP_IDLE;
    endcase
    // popping the last entry returns to the node scan
    if ((op_r == OP_TOP_DEG && st.slot_end) && st.stack_empty) op_nxt = OP_SCAN_RD;
    if (op_r == OP_TOP_RD && st.stack_empty) op_nxt = OP_SCAN_RD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_CLR_GRAPH;
      res_r <= 1'b0;
      done_r <= 1'b0;
      out_is_bipartite <= 1'b0;
      out_edges_dropped <= 1'b0;
    end else begin
      op_r <= op_nxt;
      res_r <= res_nxt;
      done_r <= op_r == OP_DONE;
      if (op_r == OP_DONE) begin
        out_is_bipartite <= res_r;
        out_edges_dropped <= overflow;
      end
    end
  end
  assign out_valid = done_r;
endmodule
`default_nettype wire

>>> hdl/bipartite_graph_check_top.sv
// bipartite_graph_check_top: stored-graph two-colouring check
// add: degree read, then degree and adjacency write; clear: sweep of all MAX_NODES degree entries;
// check: colour clearing sweep, then a scan of each node and a depth-first walk of each component
// one result beat per check, shown for one cycle on out_valid, no stall
// synchronous active-low reset, then a degree clearing pass over all MAX_NODES entries with busy high
`default_nettype none
module bipartite_graph_check_top #(
  parameter int MAX_NODES  = 1024,
  parameter int MAX_DEGREE = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [10:0] in_edge_from,
  input  wire logic [10:0] in_edge_to,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata,
  output logic             out_valid,
  output logic             out_is_bipartite,
  output logic             out_edges_dropped
);
  import bgc_pkg::*;
  logic [10:0] node_count_r;
  op_t op;
  status_t st;
  logic start_cmd, add_valid, overflow;

  always_ff @(posedge clk) begin
    if (!rst_n) node_count_r <= 11'(MAX_NODES);
    else if (cfg_we) node_count_r <= cfg_wdata;
  end

  bgc_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_action, .add_valid, .overflow, .st, .op, .busy,
    .start_cmd, .out_valid, .out_is_bipartite, .out_edges_dropped);

  bgc_datapath #(.MAX_NODES(MAX_NODES), .MAX_DEGREE(MAX_DEGREE)) u_dp (
    .clk, .rst_n, .op, .start_cmd, .node_count(node_count_r),
    .edge_from(in_edge_from), .edge_to(in_edge_to), .st, .add_valid, .overflow);

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(start && !busy)) else $error("result without work");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && action_t'(in_action) != ACT_NONE) |=> busy)
    else $error("start not taken");
  a_valid_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");
endmodule
`default_nettype wire
